### src/uvs_pkg.sv
// Shared types and vertex slot codes for the UV sphere cell vertex generator.
package uvs_pkg;

  // vertex order within a cell: a b c d c b
  localparam logic [2:0] SLOT_A  = 3'd0;
  localparam logic [2:0] SLOT_B  = 3'd1;
  localparam logic [2:0] SLOT_C  = 3'd2;
  localparam logic [2:0] SLOT_D  = 3'd3;
  localparam logic [2:0] SLOT_C2 = 3'd4;
  localparam logic [2:0] SLOT_B2 = 3'd5;

  // one vertex request: grid corner, angle steps and texcoord numerators
  typedef struct packed {
    logic [2:0]        slot;
    logic [8:0]        row;
    logic [9:0]        col;
    logic [8:0]        u;
    logic signed [9:0] v;
  } vtx_t;

  // trig factors and finished texcoords for one vertex
  typedef struct packed {
    logic [2:0]         slot;
    logic signed [15:0] cl;
    logic signed [15:0] sl;
    logic signed [15:0] cg;
    logic signed [15:0] sg;
    logic [15:0]        tu;
    logic [15:0]        tv;
  } trig_t;

endpackage

### src/uvs_cell_expand.sv
// Holds one grid cell and issues its six vertex requests, one per cycle while out_ready is high.
module uvs_cell_expand
  import uvs_pkg::*;
#(
  parameter int DIVISIONS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] lat_index,
  input  logic [7:0] lon_index,
  output logic       out_valid,
  input  logic       out_ready,
  output vtx_t       out_vtx
);

  logic       busy;
  logic [7:0] lat;
  logic [7:0] lon;
  logic [2:0] slot;
  logic       hi_row;
  logic       hi_col;
  logic       in_fire;

  // the last slot leaving frees the holder for the next cell in the same cycle
  assign in_ready  = !busy || (out_ready && slot == SLOT_B2);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= SLOT_A;
    end else if (in_fire) begin
      busy <= 1'b1;
      slot <= SLOT_A;
    end else if (busy && out_ready) begin
      if (slot == SLOT_B2) begin
        busy <= 1'b0;
      end else begin
        slot <= slot + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      lat <= lat_index;
      lon <= lon_index;
    end
  end

  always_comb begin
    unique case (slot) inside
      SLOT_A: begin
        hi_row = 1'b0;
        hi_col = 1'b0;
      end
      SLOT_B, SLOT_B2: begin
        hi_row = 1'b1;
        hi_col = 1'b0;
      end
      SLOT_C, SLOT_C2: begin
        hi_row = 1'b0;
        hi_col = 1'b1;
      end
      SLOT_D: begin
        hi_row = 1'b1;
        hi_col = 1'b1;
      end
      default: begin
        hi_row = 1'b0;
        hi_col = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_vtx.slot = slot;
    out_vtx.row  = {1'b0, lat} + 9'(hi_row);
    out_vtx.col  = {1'b0, lon, 1'b0} + (hi_col ? 10'd2 : 10'd0);
    out_vtx.u    = {1'b0, lon} + 9'(hi_col);
    // v numerator: N - i + 1 on the low row, N - i on the high row
    out_vtx.v    = $signed(10'(DIVISIONS + 1) - 10'(lat) - 10'(hi_row));
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> slot <= SLOT_B2)
    else $error("vertex slot out of range");

  a_new_cell: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> busy && slot == SLOT_A)
    else $error("accepted cell does not start at slot a");

  a_slot_step: assert property (@(posedge clk) disable iff (rst)
    (busy && out_ready && slot != SLOT_B2) |=> busy && slot == $past(slot) + 3'd1)
    else $error("vertex slot skipped or repeated");
`endif

endmodule

### src/uvs_angle.sv
// Angle reduction, sine/cosine table lookup and texcoord scaling, four stages.
module uvs_angle
  import uvs_pkg::*;
#(
  parameter int DIVISIONS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  vtx_t  in_vtx,
  output logic  out_valid,
  input  logic  out_ready,
  output trig_t out_trig
);

  localparam int TURN = 2 * DIVISIONS;
  localparam int HALF = DIVISIONS / 2;
  localparam int KW   = $clog2(TURN);
  localparam int AW   = $clog2(HALF + 1);
  // exact reciprocals: angle steps stay below 2^10, texcoord dividends below 2^25
  localparam logic [20:0] MOD_RECIP = 21'(((64'd1 << 20) + TURN - 1) / TURN);
  localparam logic [32:0] TEX_RECIP = 33'(((64'd1 << 35) + TURN - 1) / TURN);
  localparam logic [15:0] N16       = 16'(DIVISIONS);
  localparam logic [9:0]  TURN10    = 10'(TURN);
  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic signed [63:0] ONE_Q30 = 64'sd1 << 30;

  typedef struct packed {
    logic          ns;
    logic          nc;
    logic [AW-1:0] a;
  } fold_t;

  function automatic logic [63:0] sin_div(logic [63:0] x, int n);
    case (n)
      1:       return x / 64'd6;
      2:       return x / 64'd20;
      3:       return x / 64'd42;
      4:       return x / 64'd72;
      5:       return x / 64'd110;
      6:       return x / 64'd156;
      7:       return x / 64'd210;
      8:       return x / 64'd272;
      9:       return x / 64'd342;
      10:      return x / 64'd420;
      11:      return x / 64'd506;
      default: return x / 64'd600;
    endcase
  endfunction

  function automatic logic [63:0] cos_div(logic [63:0] x, int n);
    case (n)
      1:       return x / 64'd2;
      2:       return x / 64'd12;
      3:       return x / 64'd30;
      4:       return x / 64'd56;
      5:       return x / 64'd90;
      6:       return x / 64'd132;
      7:       return x / 64'd182;
      8:       return x / 64'd240;
      9:       return x / 64'd306;
      10:      return x / 64'd380;
      11:      return x / 64'd462;
      default: return x / 64'd552;
    endcase
  endfunction

  function automatic logic [15:0] to_q14(logic signed [63:0] s);
    logic signed [63:0] c;
    c = s;
    if (c < 0) c = 0;
    if (c > ONE_Q30) c = ONE_Q30;
    c = (c + 64'sd32768) >>> 16;
    return c[15:0];
  endfunction

  // Taylor series in Q30 over the first quadrant; returns {sin, cos} in Q1.14
  function automatic logic [31:0] quarter_wave(logic [63:0] ang);
    logic [63:0]        sq;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic signed [63:0] ss;
    logic signed [63:0] cs;
    sq = (ang * ang) >> 30;
    ts = ang;
    tc = 64'(ONE_Q30);
    ss = $signed(ang);
    cs = ONE_Q30;
    for (int n = 1; n <= 12; n++) begin
      ts = sin_div((ts * sq) >> 30, n);
      tc = cos_div((tc * sq) >> 30, n);
      if ((n & 1) != 0) begin
        ss = ss - $signed(ts);
        cs = cs - $signed(tc);
      end else begin
        ss = ss + $signed(ts);
        cs = cs + $signed(tc);
      end
    end
    return {to_q14(ss), to_q14(cs)};
  endfunction

  // fold a step index of the full turn into the quarter table plus signs
  function automatic fold_t fold(logic [KW-1:0] k);
    fold_t        f;
    logic [KW-1:0] a;
    a    = k;
    f.ns = 1'b0;
    f.nc = 1'b0;
    if (k >= KW'(DIVISIONS)) begin
      a    = k - KW'(DIVISIONS);
      f.ns = 1'b1;
      f.nc = 1'b1;
    end
    if ({a, 1'b0} > (KW + 1)'(DIVISIONS)) begin
      a    = KW'(DIVISIONS) - a;
      f.nc = !f.nc;
    end
    f.a = a[AW-1:0];
    return f;
  endfunction

  logic signed [15:0] qsin [HALF+1];
  logic signed [15:0] qcos [HALF+1];

  for (genvar g = 0; g <= HALF; g++) begin : g_qtab
    localparam logic [31:0] ENT = quarter_wave((PI_Q30 * 64'(g)) / DIVISIONS);
    assign qsin[g] = $signed(ENT[31:16]);
    assign qcos[g] = $signed(ENT[15:0]);
  end

  logic [3:0] vld;
  logic [3:0] en;

  always_comb begin
    en[3] = !vld[3] || out_ready;
    en[2] = !vld[2] || en[3];
    en[1] = !vld[1] || en[2];
    en[0] = !vld[0] || en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
    end
  end

  // stage A: quotients by the turn length through reciprocal multiplies
  logic [30:0] prod_row;
  logic [30:0] prod_col;
  logic [57:0] prod_tu;
  logic [57:0] prod_tv;
  vtx_t        a_vtx;
  logic [10:0] a_qrow;
  logic [10:0] a_qcol;
  logic [15:0] a_tqu;
  logic [15:0] a_tqv;

  assign prod_row = 31'(in_vtx.row) * 31'(MOD_RECIP);
  assign prod_col = 31'(in_vtx.col) * 31'(MOD_RECIP);
  // (num * 2^16 + N) / 2N; N < 2^16 so the sum is a concatenation
  assign prod_tu  = 58'({in_vtx.u, N16}) * 58'(TEX_RECIP);
  assign prod_tv  = 58'({in_vtx.v[8:0], N16}) * 58'(TEX_RECIP);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_vtx  <= in_vtx;
      a_qrow <= prod_row[30:20];
      a_qcol <= prod_col[30:20];
      a_tqu  <= prod_tu[50:35];
      a_tqv  <= prod_tv[50:35];
    end
  end

  // stage B: remainders and texcoord clamps
  logic [10:0]   krow_full;
  logic [10:0]   kcol_full;
  logic [15:0]   tu_next;
  logic [15:0]   tv_next;
  logic [2:0]    b_slot;
  logic [KW-1:0] b_krow;
  logic [KW-1:0] b_kcol;
  logic [15:0]   b_tu;
  logic [15:0]   b_tv;

  assign krow_full = 11'(a_vtx.row) - a_qrow * 11'(TURN);
  assign kcol_full = 11'(a_vtx.col) - a_qcol * 11'(TURN);

  always_comb begin
    if (a_vtx.u == 9'd0) begin
      tu_next = 16'd0;
    end else if (10'(a_vtx.u) >= TURN10) begin
      tu_next = 16'hFFFF;
    end else begin
      tu_next = a_tqu;
    end
    if (a_vtx.v <= 10'sd0) begin
      tv_next = 16'd0;
    end else if (10'(a_vtx.v[8:0]) >= TURN10) begin
      tv_next = 16'hFFFF;
    end else begin
      tv_next = a_tqv;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_slot <= a_vtx.slot;
      b_krow <= krow_full[KW-1:0];
      b_kcol <= kcol_full[KW-1:0];
      b_tu   <= tu_next;
      b_tv   <= tv_next;
    end
  end

  // stage C: quadrant fold
  logic [2:0]  c_slot;
  fold_t       c_row;
  fold_t       c_col;
  logic [15:0] c_tu;
  logic [15:0] c_tv;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_slot <= b_slot;
      c_row  <= fold(b_krow);
      c_col  <= fold(b_kcol);
      c_tu   <= b_tu;
      c_tv   <= b_tv;
    end
  end

  // stage D: table lookup and sign restore
  logic signed [15:0] rs;
  logic signed [15:0] rc;
  logic signed [15:0] gs;
  logic signed [15:0] gc;
  trig_t              trig_next;

  always_comb begin
    rs = qsin[c_row.a];
    rc = qcos[c_row.a];
    gs = qsin[c_col.a];
    gc = qcos[c_col.a];
    trig_next.slot = c_slot;
    trig_next.cl   = c_row.ns ? -rs : rs;
    // sin(lat) is minus the cosine of the row step
    trig_next.sl   = c_row.nc ? rc : -rc;
    trig_next.cg   = c_col.nc ? -gc : gc;
    trig_next.sg   = c_col.ns ? -gs : gs;
    trig_next.tu   = c_tu;
    trig_next.tv   = c_tv;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      out_trig <= trig_next;
    end
  end

endmodule

### src/uvs_pos.sv
// Position products, rounding and saturation, with the output register.
module uvs_pos
  import uvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  trig_t       in_trig,
  input  logic [14:0] radius,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_slot,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic [15:0] pos_z,
  output logic [15:0] tex_u,
  output logic [15:0] tex_v,
  output logic        last_vertex
);

  // round half away from zero by sh bits, then saturate to signed 16 bits
  function automatic logic [15:0] round_sat(logic signed [47:0] p, int sh);
    logic [47:0] m;
    logic [47:0] half;
    m    = p[47] ? 48'(-p) : 48'(p);
    half = 48'd1 << (sh - 1);
    m    = (m + half) >> sh;
    if (p[47]) begin
      return (m > 48'd32768) ? 16'h8000 : 16'(-m);
    end
    return (m > 48'd32767) ? 16'h7FFF : m[15:0];
  endfunction

  logic [2:0] vld;
  logic [2:0] en;

  always_comb begin
    en[2] = !vld[2] || out_ready;
    en[1] = !vld[1] || en[2];
    en[0] = !vld[0] || en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  // stage 1: radius times the latitude factors
  logic signed [15:0] rad_s;
  logic [2:0]         p1_slot;
  logic signed [31:0] p1_rcl;
  logic signed [31:0] p1_rsl;
  logic signed [15:0] p1_cg;
  logic signed [15:0] p1_sg;
  logic [15:0]        p1_tu;
  logic [15:0]        p1_tv;

  assign rad_s = $signed({1'b0, radius});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1_slot <= in_trig.slot;
      p1_rcl  <= rad_s * in_trig.cl;
      p1_rsl  <= rad_s * in_trig.sl;
      p1_cg   <= in_trig.cg;
      p1_sg   <= in_trig.sg;
      p1_tu   <= in_trig.tu;
      p1_tv   <= in_trig.tv;
    end
  end

  // stage 2: times the longitude factors
  logic [2:0]         p2_slot;
  logic signed [47:0] p2_px;
  logic signed [47:0] p2_pz;
  logic signed [31:0] p2_rsl;
  logic [15:0]        p2_tu;
  logic [15:0]        p2_tv;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p2_slot <= p1_slot;
      p2_px   <= 48'(p1_rcl) * 48'(p1_cg);
      p2_pz   <= 48'(p1_rcl) * 48'(p1_sg);
      p2_rsl  <= p1_rsl;
      p2_tu   <= p1_tu;
      p2_tv   <= p1_tv;
    end
  end

  // stage 3: back to Q8.8 into the output register
  always_ff @(posedge clk) begin
    if (en[2]) begin
      out_slot    <= p2_slot;
      pos_x       <= round_sat(p2_px, 28);
      pos_y       <= round_sat(48'(p2_rsl), 14);
      pos_z       <= round_sat(p2_pz, 28);
      tex_u       <= p2_tu;
      tex_v       <= p2_tv;
      last_vertex <= (p2_slot == SLOT_B2);
    end
  end

endmodule

### src/uv_sphere_cell_vertices_core.sv
// UV sphere cell vertex generator: one grid cell in, six vertices (two triangles) out.
// Throughput: one vertex per cycle unless the output stalls, set by the single vertex output.
// A new cell can be taken in the same cycle as the previous cell's last vertex leaves the cell holder.
// Pipeline: cell holder, 4 angle/table stages, 3 multiply/round stages ending in the output register.
// Reset clears all valid bits and sets the radius to 1.0; there is no clearing pass.
module uv_sphere_cell_vertices_core
  import uvs_pkg::*;
#(
  parameter int DIVISIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // lat_index[7:0], lon_index[15:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v (16 bits each)
  output logic [2:0]  m_axis_tuser,   // vertex_slot
  output logic        m_axis_tlast,   // last_vertex
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);

  logic [14:0] sphere_radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= 15'd256;
    end else if (cfg_valid && cfg_ready) begin
      sphere_radius <= cfg_data;
    end
  end

  logic  vtx_valid;
  logic  vtx_ready;
  vtx_t  vtx;
  logic  trig_valid;
  logic  trig_ready;
  trig_t trig;

  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] pos_z;
  logic [15:0] tex_u;
  logic [15:0] tex_v;

  uvs_cell_expand #(
    .DIVISIONS (DIVISIONS)
  ) u_expand (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .lat_index (s_axis_tdata[7:0]),
    .lon_index (s_axis_tdata[15:8]),
    .out_valid (vtx_valid),
    .out_ready (vtx_ready),
    .out_vtx   (vtx)
  );

  uvs_angle #(
    .DIVISIONS (DIVISIONS)
  ) u_angle (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vtx_valid),
    .in_ready  (vtx_ready),
    .in_vtx    (vtx),
    .out_valid (trig_valid),
    .out_ready (trig_ready),
    .out_trig  (trig)
  );

  uvs_pos u_pos (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (trig_valid),
    .in_ready    (trig_ready),
    .in_trig     (trig),
    .radius      (sphere_radius),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_slot    (m_axis_tuser),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .last_vertex (m_axis_tlast)
  );

  assign m_axis_tdata = {tex_v, tex_u, pos_z, pos_y, pos_x};

endmodule
